FILE: design/rotary_encoder_acceleration_macros.svh
// Assertion macros for the rotary encoder acceleration block.
`ifndef ROTARY_ENCODER_ACCELERATION_MACROS_SVH
`define ROTARY_ENCODER_ACCELERATION_MACROS_SVH
`ifndef NO_ASSERTIONS
`define REA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rea: assertion failed");
`define REA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("rea: assertion failed");
`else
`define REA_ASSERT(lbl, prop)
`define REA_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: design/rea_pkg.sv
// Shared types, widths and constants of the rotary encoder acceleration block.
`timescale 1ns / 1ps
package rea_pkg;

  localparam int unsigned POS_W  = 32;
  localparam int unsigned IV_W   = 16;
  localparam int unsigned MULT_W = 10;
  localparam int unsigned NUM_W  = IV_W + MULT_W;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam logic [IV_W-1:0]   SLOW_RST = IV_W'(200);
  localparam logic [IV_W-1:0]   FAST_RST = IV_W'(20);
  localparam logic [MULT_W-1:0] MMAX_RST = MULT_W'(10);

  localparam logic [2:0] REG_SLOW    = 3'd0;
  localparam logic [2:0] REG_FAST    = 3'd1;
  localparam logic [2:0] REG_MMAX    = 3'd2;
  localparam logic [2:0] REG_MAX_EN  = 3'd3;
  localparam logic [2:0] REG_MAX_LIM = 3'd4;
  localparam logic [2:0] REG_MIN_EN  = 3'd5;
  localparam logic [2:0] REG_MIN_LIM = 3'd6;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_e;

  typedef struct packed {
    logic [IV_W-1:0]   slow;
    logic [IV_W-1:0]   fast;
    logic [MULT_W-1:0] mmax;
    logic              max_en;
    logic [POS_W-1:0]  max_lim;
    logic              min_en;
    logic [POS_W-1:0]  min_lim;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic div_start;
    logic div_take;
    logic mul;
    logic add;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic moved;
    logic need_div;
    logic div_done;
  } sts_t;

endpackage

FILE: design/rea_div.sv
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module rea_div import rea_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [IV_W-1:0]   den_i,
  output logic              done_o,
  output logic [NUM_W-1:0]  quot_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [IV_W-1:0]  rem_q, rem_d;
  logic [IV_W-1:0]  den_q, den_d;
  logic [IV_W:0]    rem_sh;
  logic [IV_W:0]    rem_sub;

  assign rem_sh  = {rem_q, quo_q[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W);
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = rem_sub[IV_W-1:0];
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[IV_W-1:0];
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

FILE: design/rea_dp.sv
// Datapath: item registers, position state, divider, multiplier, clamping and result register.
`timescale 1ns / 1ps
module rea_dp import rea_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic              opcode_i,
  input  logic [POS_W-1:0]  raw_position_i,
  input  logic [IV_W-1:0]   interval_ms_i,
  input  logic [POS_W-1:0]  new_position_i,
  output logic [POS_W-1:0]  position_o,
  output logic              changed_o,
  output logic [MULT_W-1:0] step_multiplier_o
);

  logic              op_q;
  logic [POS_W-1:0]  raw_q, npos_q;
  logic [IV_W-1:0]   iv_q;
  logic [POS_W-1:0]  last_raw_q, acc_q;
  dir_e              dir_q;
  logic [POS_W-1:0]  delta_q, prod_q, res_pos_q;
  dir_e              new_dir_q;
  logic [NUM_W-1:0]  num_q;
  logic [IV_W-1:0]   den_q;
  logic [MULT_W-1:0] mult_q;
  logic              res_chg_q;
  logic [POS_W-1:0]  out_pos_q;
  logic              out_chg_q;
  logic [MULT_W-1:0] out_mult_q;

  logic [POS_W-1:0]        delta;
  dir_e                    dir_now;
  logic [MULT_W-1:0]       mmax;
  logic                    unity, full, moved;
  logic [IV_W-1:0]         ivc;
  logic [NUM_W-1:0]        num;
  logic [POS_W-1:0]        prod_full;
  logic [POS_W-1:0]        sum, clamp_hi, clamp_lo;
  logic                    div_done;
  logic [NUM_W-1:0]        quot;

  assign delta   = raw_q - last_raw_q;
  assign dir_now = delta[POS_W-1] ? DIR_DOWN : DIR_UP;
  assign mmax    = (cfg_i.mmax == '0) ? MULT_W'(1) : cfg_i.mmax;
  assign moved   = !op_q && (delta != '0);
  assign unity   = (dir_q != dir_now) || (iv_q >= cfg_i.slow);
  assign full    = cfg_i.fast >= cfg_i.slow;
  assign ivc     = (iv_q < cfg_i.fast) ? cfg_i.fast : iv_q;
  assign num     = NUM_W'(cfg_i.slow - ivc) * NUM_W'(mmax - MULT_W'(1));

  assign prod_full = delta_q * POS_W'(mult_q);
  assign sum       = acc_q + prod_q;
  assign clamp_hi  = (cfg_i.max_en && ($signed(sum) > $signed(cfg_i.max_lim)))
                     ? cfg_i.max_lim : sum;
  assign clamp_lo  = (cfg_i.min_en && ($signed(clamp_hi) < $signed(cfg_i.min_lim)))
                     ? cfg_i.min_lim : clamp_hi;

  rea_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign sts_o.moved    = moved;
  assign sts_o.need_div = moved && !unity && !full;
  assign sts_o.div_done = div_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q <= '0;
      acc_q      <= '0;
      dir_q      <= DIR_NONE;
    end else if (cmd_i.commit) begin
      last_raw_q <= raw_q;
      acc_q      <= res_pos_q;
      dir_q      <= new_dir_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= opcode_i;
      raw_q  <= raw_position_i;
      iv_q   <= interval_ms_i;
      npos_q <= new_position_i;
    end
    if (cmd_i.prep) begin
      delta_q   <= delta;
      num_q     <= num;
      den_q     <= cfg_i.slow - cfg_i.fast;
      mult_q    <= (moved && !unity) ? mmax : MULT_W'(1);
      res_pos_q <= op_q ? npos_q : acc_q;
      res_chg_q <= op_q;
      new_dir_q <= op_q ? DIR_NONE : (moved ? dir_now : dir_q);
    end
    if (cmd_i.div_take) begin
      mult_q <= MULT_W'(1) + quot[MULT_W-1:0];
    end
    if (cmd_i.mul) begin
      prod_q <= prod_full;
    end
    if (cmd_i.add) begin
      res_pos_q <= clamp_lo;
      res_chg_q <= clamp_lo != acc_q;
    end
    if (cmd_i.commit) begin
      out_pos_q  <= res_pos_q;
      out_chg_q  <= res_chg_q;
      out_mult_q <= mult_q;
    end
  end

  assign position_o        = out_pos_q;
  assign changed_o         = out_chg_q;
  assign step_multiplier_o = out_mult_q;

endmodule

FILE: design/rea_ctrl.sv
// Controller: sequences one item through the datapath and owns the output valid.
`timescale 1ns / 1ps
module rea_ctrl import rea_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DSTART,
    S_DIV,
    S_MUL,
    S_ADD,
    S_COMMIT
  } state_e;

  state_e state_q, state_d;
  logic   stall_q, out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        if (sts_i.need_div) state_d = S_DSTART;
        else if (sts_i.moved) state_d = S_MUL;
        else state_d = S_COMMIT;
      end
      S_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d        = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_ADD;
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = S_COMMIT;
      end
      S_COMMIT: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (cmd_o.commit) out_valid_d = 1'b1;
    else out_valid_d = out_valid_q && out_stall_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      stall_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stall_q     <= state_d != S_IDLE;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = stall_q;
  assign out_valid_o = out_valid_q;

endmodule

FILE: design/rotary_encoder_acceleration.sv
// Top level: configuration registers, controller and datapath of the accelerated encoder.
// Set and no-move items pass the prepare and commit states; unity or maximum steps add
// the multiply and add states; an interpolated multiplier first waits on the 26-step serial
// divider. A new item is taken only once the last one is committed, and it is taken while a
// result waits in the output register. Reset clears position state, direction, output
// valid and sets the configuration registers to their documented defaults.
`timescale 1ns / 1ps
`include "rotary_encoder_acceleration_macros.svh"
module rotary_encoder_acceleration import rea_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              opcode_i,
  input  logic [POS_W-1:0]  raw_position_i,
  input  logic [IV_W-1:0]   interval_ms_i,
  input  logic [POS_W-1:0]  new_position_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [POS_W-1:0]  position_o,
  output logic              changed_o,
  output logic [MULT_W-1:0] step_multiplier_o
);

  cfg_t       cfg_q;
  cmd_t       cmd;
  sts_t       sts;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slow    <= SLOW_RST;
      cfg_q.fast    <= FAST_RST;
      cfg_q.mmax    <= MMAX_RST;
      cfg_q.max_en  <= 1'b0;
      cfg_q.max_lim <= '0;
      cfg_q.min_en  <= 1'b0;
      cfg_q.min_lim <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_SLOW:    cfg_q.slow    <= pwdata[IV_W-1:0];
        REG_FAST:    cfg_q.fast    <= pwdata[IV_W-1:0];
        REG_MMAX:    cfg_q.mmax    <= pwdata[MULT_W-1:0];
        REG_MAX_EN:  cfg_q.max_en  <= pwdata[0];
        REG_MAX_LIM: cfg_q.max_lim <= pwdata[POS_W-1:0];
        REG_MIN_EN:  cfg_q.min_en  <= pwdata[0];
        REG_MIN_LIM: cfg_q.min_lim <= pwdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SLOW:    prdata = DATA_W'(cfg_q.slow);
      REG_FAST:    prdata = DATA_W'(cfg_q.fast);
      REG_MMAX:    prdata = DATA_W'(cfg_q.mmax);
      REG_MAX_EN:  prdata = DATA_W'(cfg_q.max_en);
      REG_MAX_LIM: prdata = cfg_q.max_lim;
      REG_MIN_EN:  prdata = DATA_W'(cfg_q.min_en);
      REG_MIN_LIM: prdata = cfg_q.min_lim;
      default:     prdata = '0;
    endcase
  end

  rea_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rea_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .opcode_i          (opcode_i),
    .raw_position_i    (raw_position_i),
    .interval_ms_i     (interval_ms_i),
    .new_position_i    (new_position_i),
    .position_o        (position_o),
    .changed_o         (changed_o),
    .step_multiplier_o (step_multiplier_o)
  );

  `REA_ASSERT(a_busy_after_transfer, (in_valid_i && !in_stall_o) |=> in_stall_o)
  `REA_ASSERT(a_result_while_busy, $rose(out_valid_o) |-> $past(in_stall_o))
  `REA_ASSERT(a_mult_nonzero, out_valid_o |-> (step_multiplier_o != '0))
  `REA_ASSERT_ALWAYS(a_reset_no_result, !rst_ni |-> (!out_valid_o && !in_stall_o))

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the accelerated rotary encoder: directed rows, random phases, APB setup.
`timescale 1ns / 1ps
module tb_top;
  import rea_pkg::*;

  localparam logic        OP_UPDATE   = 1'b0;
  localparam logic        OP_SET      = 1'b1;
  localparam int unsigned LAST_PHASE  = 7;
  localparam int unsigned PHASE_ITEMS = 150;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT = 500000;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;
  typedef enum logic [1:0] {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic              changed;
    logic [MULT_W-1:0] mult;
  } reading_t;

  typedef struct packed {
    row_kind_e         kind;
    logic [2:0]        reg_idx;
    logic [DATA_W-1:0] value;
    logic              op;
    logic [POS_W-1:0]  raw;
    logic [IV_W-1:0]   iv;
    logic [POS_W-1:0]  npos;
    logic              typed;
    reading_t          want;
  } stim_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              opcode_i = 1'b0;
  logic [POS_W-1:0]  raw_position_i = '0;
  logic [IV_W-1:0]   interval_ms_i = '0;
  logic [POS_W-1:0]  new_position_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [POS_W-1:0]  position_o;
  logic              changed_o;
  logic [MULT_W-1:0] step_multiplier_o;

  logic [IV_W-1:0]   cfg_slow = SLOW_RST;
  logic [IV_W-1:0]   cfg_fast = FAST_RST;
  logic [MULT_W-1:0] cfg_mmax = MMAX_RST;
  logic              cfg_max_en = 1'b0;
  logic [POS_W-1:0]  cfg_max_lim = '0;
  logic              cfg_min_en = 1'b0;
  logic [POS_W-1:0]  cfg_min_lim = '0;

  logic [POS_W-1:0]  enc_last_raw = '0;
  logic [POS_W-1:0]  enc_position = '0;
  dir_e              enc_dir = DIR_NONE;

  reading_t          readings_due[$];
  stim_row_t         stim_rows[$];
  reading_t          predicted;
  int unsigned       tx_idle_pct = 0;
  int unsigned       rx_stall_pct = 0;
  int unsigned       mismatches = 0;
  int unsigned       cycle_count = 0;
  logic              run_up = 1'b1;
  logic              squeeze_go = 1'b0;
  logic              hold_rx = 1'b0;

  rotary_encoder_acceleration DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .opcode_i          (opcode_i),
    .raw_position_i    (raw_position_i),
    .interval_ms_i     (interval_ms_i),
    .new_position_i    (new_position_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .position_o        (position_o),
    .changed_o         (changed_o),
    .step_multiplier_o (step_multiplier_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic reading_t step_encoder(logic op, logic [POS_W-1:0] raw,
                                            logic [IV_W-1:0] iv, logic [POS_W-1:0] npos);
    reading_t         r;
    logic [POS_W-1:0] delta;
    logic [POS_W-1:0] prev;
    logic [POS_W-1:0] sum;
    dir_e             dir;
    int unsigned      m;
    int unsigned      mtop;
    int unsigned      ivc;
    r.changed = 1'b0;
    r.mult = MULT_W'(1);
    if (op == OP_SET) begin
      enc_last_raw = raw;
      enc_position = npos;
      enc_dir = DIR_NONE;
      r.changed = 1'b1;
    end else begin
      delta = raw - enc_last_raw;
      if (delta != '0) begin
        dir = delta[POS_W-1] ? DIR_DOWN : DIR_UP;
        mtop = (cfg_mmax == '0) ? 1 : 32'(cfg_mmax);
        ivc = 32'(iv);
        if (enc_dir != dir || ivc >= 32'(cfg_slow)) begin
          m = 1;
        end else if (cfg_fast >= cfg_slow) begin
          m = mtop;
        end else begin
          if (ivc < 32'(cfg_fast)) ivc = 32'(cfg_fast);
          m = 1 + ((32'(cfg_slow) - ivc) * (mtop - 1)) / 32'(cfg_slow - cfg_fast);
          if (m > mtop) m = mtop;
        end
        prev = enc_position;
        sum = prev + delta * m;
        if (cfg_max_en && $signed(sum) > $signed(cfg_max_lim)) sum = cfg_max_lim;
        if (cfg_min_en && $signed(sum) < $signed(cfg_min_lim)) sum = cfg_min_lim;
        enc_position = sum;
        enc_last_raw = raw;
        enc_dir = dir;
        r.changed = (sum != prev);
        r.mult = m[MULT_W-1:0];
      end
    end
    r.position = enc_position;
    return r;
  endfunction

  function automatic stim_row_t item_row(logic op, logic [POS_W-1:0] raw,
                                         logic [IV_W-1:0] iv, logic [POS_W-1:0] npos);
    stim_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.op = op;
    r.raw = raw;
    r.iv = iv;
    r.npos = npos;
    return r;
  endfunction

  function automatic stim_row_t known_row(logic op, logic [POS_W-1:0] raw,
                                          logic [IV_W-1:0] iv, logic [POS_W-1:0] npos,
                                          logic [POS_W-1:0] pos, logic chg,
                                          logic [MULT_W-1:0] mult);
    stim_row_t r;
    r = item_row(op, raw, iv, npos);
    r.typed = 1'b1;
    r.want.position = pos;
    r.want.changed = chg;
    r.want.mult = mult;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [2:0] idx, logic [DATA_W-1:0] value);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.value = value;
    return r;
  endfunction

  task automatic set_idling(idle_mode_e mode);
    tx_idle_pct = (mode == IDLE_TX) ? 78 : (mode == IDLE_BOTH) ? 12 : 0;
    rx_stall_pct = (mode == IDLE_RX) ? 78 : (mode == IDLE_BOTH) ? 12 : 0;
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [DATA_W-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SLOW:    cfg_slow = value[IV_W-1:0];
      REG_FAST:    cfg_fast = value[IV_W-1:0];
      REG_MMAX:    cfg_mmax = value[MULT_W-1:0];
      REG_MAX_EN:  cfg_max_en = value[0];
      REG_MAX_LIM: cfg_max_lim = value[POS_W-1:0];
      REG_MIN_EN:  cfg_min_en = value[0];
      REG_MIN_LIM: cfg_min_lim = value[POS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic offer_item(logic op, logic [POS_W-1:0] raw, logic [IV_W-1:0] iv,
                            logic [POS_W-1:0] npos);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    raw_position_i <= raw;
    interval_ms_i <= iv;
    new_position_i <= npos;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
  endtask

  task automatic drain_readings();
    in_valid_i <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random_item();
    logic             op;
    logic [POS_W-1:0] raw;
    logic [POS_W-1:0] npos;
    logic [IV_W-1:0]  iv;
    int unsigned      pick;
    int unsigned      span;
    int unsigned      stride;
    pick = $urandom_range(99);
    op = OP_UPDATE;
    npos = $urandom;
    span = 32'(cfg_slow);
    span = span + span / 4 + 4;
    if (span > 65535) span = 65535;
    iv = ($urandom_range(9) == 0) ? IV_W'($urandom) : IV_W'($urandom_range(span));
    if (pick < 5) begin
      op = OP_SET;
      raw = $urandom;
      if ($urandom_range(2) != 0) npos = POS_W'($urandom_range(4000)) - POS_W'(2000);
    end else if (pick < 11) begin
      raw = $urandom;
    end else if (pick < 17) begin
      raw = enc_last_raw;
    end else begin
      if ($urandom_range(99) < 15) run_up = !run_up;
      stride = $urandom_range(1, 4);
      raw = run_up ? enc_last_raw + stride : enc_last_raw - stride;
    end
    offer_item(op, raw, iv, npos);
    readings_due.push_back(step_encoder(op, raw, iv, npos));
  endtask

  task automatic choose_config(int unsigned p);
    logic [IV_W-1:0]   slow;
    logic [IV_W-1:0]   fast;
    logic [MULT_W-1:0] mmax;
    logic [POS_W-1:0]  hi;
    logic [POS_W-1:0]  lo;
    logic [POS_W-1:0]  tmp;
    logic              hi_en;
    logic              lo_en;
    if (p == 0) begin
      slow = SLOW_RST;
      fast = FAST_RST;
      mmax = MMAX_RST;
      hi = '0;
      lo = '0;
      hi_en = 1'b0;
      lo_en = 1'b0;
    end else if (p == LAST_PHASE) begin
      slow = '1;
      fast = '0;
      mmax = '1;
      hi = 32'h7FFF_FFFF;
      lo = 32'h8000_0000;
      hi_en = 1'b1;
      lo_en = 1'b1;
    end else begin
      slow = ($urandom_range(4) == 0) ? IV_W'($urandom) : IV_W'($urandom_range(1, 400));
      fast = ($urandom_range(4) == 0) ? IV_W'($urandom) : IV_W'($urandom_range(slow));
      mmax = ($urandom_range(7) == 0) ? '0 : MULT_W'($urandom_range(1, 1023));
      hi = enc_position + $urandom_range(3000);
      lo = enc_position - $urandom_range(3000);
      if ($urandom_range(4) == 0) begin
        tmp = hi;
        hi = lo;
        lo = tmp;
      end
      hi_en = 1'($urandom_range(1));
      lo_en = 1'($urandom_range(1));
    end
    cfg_write(REG_SLOW, DATA_W'(slow));
    cfg_write(REG_FAST, DATA_W'(fast));
    cfg_write(REG_MMAX, DATA_W'(mmax));
    cfg_write(REG_MAX_EN, DATA_W'(hi_en));
    cfg_write(REG_MAX_LIM, DATA_W'(hi));
    cfg_write(REG_MIN_EN, DATA_W'(lo_en));
    cfg_write(REG_MIN_LIM, DATA_W'(lo));
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= hold_rx || ($urandom_range(99) < rx_stall_pct);
  end

  // Hold the receiver off for a long stretch so the block backs up.
  initial begin
    wait (squeeze_go);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (readings_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transfer: position %h changed %b mult %0d",
                   position_o, changed_o, step_multiplier_o);
      end else begin
        want = readings_due.pop_front();
        if (position_o !== want.position || changed_o !== want.changed ||
            step_multiplier_o !== want.mult) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: position exp %h got %h, changed exp %b got %b, mult exp %0d got %0d",
                     want.position, position_o, want.changed, changed_o,
                     want.mult, step_multiplier_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_ni <= 1'b0;
    stim_rows.push_back(known_row(OP_UPDATE, 32'd0, 16'd0, 32'd0, 32'd0, 1'b0, 10'd1));
    stim_rows.push_back(known_row(OP_UPDATE, 32'd5, 16'd100, 32'd0, 32'd5, 1'b1, 10'd1));
    stim_rows.push_back(known_row(OP_UPDATE, 32'd6, 16'd20, 32'd0, 32'd15, 1'b1, 10'd10));
    stim_rows.push_back(known_row(OP_UPDATE, 32'd7, 16'd0, 32'd0, 32'd25, 1'b1, 10'd10));
    stim_rows.push_back(known_row(OP_UPDATE, 32'd8, 16'd200, 32'd0, 32'd26, 1'b1, 10'd1));
    stim_rows.push_back(known_row(OP_UPDATE, 32'd9, 16'hFFFF, 32'd0, 32'd27, 1'b1, 10'd1));
    stim_rows.push_back(item_row(OP_UPDATE, 32'd10, 16'd110, 32'd0));
    stim_rows.push_back(item_row(OP_UPDATE, 32'd9, 16'd10, 32'd0));
    stim_rows.push_back(item_row(OP_UPDATE, 32'd8, 16'd10, 32'd0));
    stim_rows.push_back(known_row(OP_SET, 32'h7FFF_FFFF, 16'hFFFF, 32'h7FFF_FFFE,
                                  32'h7FFF_FFFE, 1'b1, 10'd1));
    stim_rows.push_back(item_row(OP_UPDATE, 32'h8000_0000, 16'd100, 32'hFFFF_FFFF));
    stim_rows.push_back(item_row(OP_UPDATE, 32'h8000_0001, 16'd20, 32'd0));
    stim_rows.push_back(known_row(OP_SET, 32'd0, 16'd0, 32'h8000_0000,
                                  32'h8000_0000, 1'b1, 10'd1));
    stim_rows.push_back(item_row(OP_UPDATE, 32'hFFFF_FFFF, 16'hFFFF, 32'd0));
    stim_rows.push_back(known_row(OP_SET, 32'd0, 16'd0, 32'd0, 32'd0, 1'b1, 10'd1));
    stim_rows.push_back(item_row(OP_UPDATE, 32'h8000_0000, 16'd0, 32'd0));
    stim_rows.push_back(cfg_row(REG_FAST, 32'd200));
    stim_rows.push_back(known_row(OP_SET, 32'd0, 16'd0, 32'd0, 32'd0, 1'b1, 10'd1));
    stim_rows.push_back(item_row(OP_UPDATE, 32'd1, 16'd10, 32'd0));
    stim_rows.push_back(item_row(OP_UPDATE, 32'd2, 16'd199, 32'd0));
    stim_rows.push_back(cfg_row(REG_FAST, 32'd300));
    stim_rows.push_back(item_row(OP_UPDATE, 32'd3, 16'd50, 32'd0));
    stim_rows.push_back(cfg_row(REG_MMAX, 32'd0));
    stim_rows.push_back(item_row(OP_UPDATE, 32'd4, 16'd50, 32'd0));
    stim_rows.push_back(cfg_row(REG_SLOW, 32'hFFFF));
    stim_rows.push_back(cfg_row(REG_FAST, 32'd0));
    stim_rows.push_back(cfg_row(REG_MMAX, 32'd1023));
    stim_rows.push_back(item_row(OP_UPDATE, 32'd5, 16'd0, 32'd0));
    stim_rows.push_back(cfg_row(REG_MAX_LIM, 32'd100));
    stim_rows.push_back(cfg_row(REG_MAX_EN, 32'd1));
    stim_rows.push_back(cfg_row(REG_MIN_LIM, 32'd200));
    stim_rows.push_back(cfg_row(REG_MIN_EN, 32'd1));
    stim_rows.push_back(item_row(OP_UPDATE, 32'd6, 16'd0, 32'd0));
    stim_rows.push_back(item_row(OP_UPDATE, 32'd6, 16'd0, 32'd0));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idling(IDLE_NONE);
    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) begin
        drain_readings();
        cfg_write(stim_rows[i].reg_idx, stim_rows[i].value);
      end else begin
        offer_item(stim_rows[i].op, stim_rows[i].raw, stim_rows[i].iv, stim_rows[i].npos);
        predicted = step_encoder(stim_rows[i].op, stim_rows[i].raw, stim_rows[i].iv,
                                 stim_rows[i].npos);
        readings_due.push_back(stim_rows[i].typed ? stim_rows[i].want : predicted);
      end
    end

    for (int unsigned p = 0; p <= LAST_PHASE; p++) begin
      drain_readings();
      choose_config(p);
      set_idling(idle_mode_e'(p % 4));
      repeat (PHASE_ITEMS) send_random_item();
    end

    // Keep offering transfers while the receiver is held off.
    set_idling(IDLE_NONE);
    squeeze_go = 1'b1;
    repeat (24) send_random_item();

    drain_readings();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/rea_pkg.sv
design/rea_div.sv
design/rea_dp.sv
design/rea_ctrl.sv
design/rotary_encoder_acceleration.sv
bench/tb_top.sv
